### sv/mmep_pkg.sv
// ----------------------------------------------------------------------------
// mmep_pkg
// Shared widths, limits and state codes of the min/max envelope pyramid.
// ----------------------------------------------------------------------------
package mmep_pkg;

  localparam int FRAME_W     = 32;   // frame counts and positions
  localparam int LEVEL_W     = 3;    // level field of a result
  localparam int INDEX_W     = 16;   // entry index field of a result
  localparam int CCOUNT_W    = 4;    // channel_count register
  localparam int CSEL_W      = 3;    // channel_select register
  localparam int TPOINTS_W   = 17;   // target_points register
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int LEVEL_LIMIT = 512;  // a level above this size gets a coarser one

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT    = 2'd0,
    CFG_CHANNEL_COUNT  = 2'd1,
    CFG_CHANNEL_SELECT = 2'd2,
    CFG_TARGET_POINTS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'b01,
    DV_RUN  = 2'b10
  } div_state_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } back_state_t;

endpackage

### sv/mmep_fifo.sv
// ----------------------------------------------------------------------------
// mmep_fifo
// Small register queue with flush, head shown while not empty.
// ----------------------------------------------------------------------------
module mmep_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
    if (clear) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### sv/mmep_div.sv
// ----------------------------------------------------------------------------
// mmep_div
// Restoring divider, one quotient bit per cycle: frames per bucket and the
// remainder that drives the bucket end accumulator.
// ----------------------------------------------------------------------------
module mmep_div
  import mmep_pkg::*;
#(
  parameter int BW = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [FRAME_W-1:0] dividend,
  input  logic [BW-1:0]      divisor,
  output logic [FRAME_W-1:0] quotient,
  output logic [BW-1:0]      remainder,
  output logic               busy,
  output logic               done
);

  localparam int SW = $clog2(FRAME_W);

  div_state_t         state_r, state_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [FRAME_W-1:0] quo_r, quo_nxt;
  logic [BW-1:0]      rem_r, rem_nxt;
  logic               done_r, done_nxt;
  logic [BW:0]        trial;
  logic [BW:0]        diff;

  assign trial = {rem_r, quo_r[FRAME_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DV_IDLE: begin
      end
      DV_RUN: begin
        // dividend bits shift out of the top while quotient bits enter below
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = diff[BW-1:0];
          quo_nxt = {quo_r[FRAME_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[BW-1:0];
          quo_nxt = {quo_r[FRAME_W-2:0], 1'b0};
        end
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(FRAME_W - 1)) begin
          state_nxt = DV_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
    // a new start always begins afresh, so the last of several writes counts
    if (start) begin
      quo_nxt   = dividend;
      rem_nxt   = '0;
      step_nxt  = '0;
      state_nxt = DV_RUN;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign busy      = (state_r == DV_RUN) || done_r;
  assign done      = done_r;

endmodule

### sv/mmep_front.sv
// ----------------------------------------------------------------------------
// mmep_front
// Takes interleaved samples, keeps the selected channel, tracks bucket ends
// and hands each closed bucket to the pyramid builder.
// ----------------------------------------------------------------------------
module mmep_front
  import mmep_pkg::*;
#(
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_CHANNELS = 8,
  parameter int BW           = 17,
  parameter int BKT_W        = BW + FRAME_W + 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic                          init,
  input  logic                          busy,
  input  logic                          setup_ok,
  input  logic [FRAME_W-1:0]            frame_count,
  input  logic [CCOUNT_W-1:0]           channel_count,
  input  logic [CSEL_W-1:0]             channel_select,
  input  logic [BW-1:0]                 bucket_total,
  input  logic [FRAME_W-1:0]            step_q,
  input  logic [BW-1:0]                 step_r,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          full,
  output logic                          bq_push,
  output logic [BKT_W-1:0]              bq_data,
  input  logic                          bq_full
);

  localparam int CPW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic signed [SAMPLE_BITS-1:0] S_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [FRAME_W-1:0]            fpos_r, fpos_nxt;
  logic [CPW-1:0]                cpos_r, cpos_nxt;
  logic [BW-1:0]                 bnum_r, bnum_nxt;
  logic [FRAME_W-1:0]            end_r, end_nxt;
  logic [FRAME_W-1:0]            bstart_r, bstart_nxt;
  logic [BW-1:0]                 acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] rmin_r, rmin_nxt;
  logic signed [SAMPLE_BITS-1:0] rmax_r, rmax_nxt;

  logic                          accept, active, hit, frame_done, bucket_done;
  logic [CCOUNT_W-1:0]           cc_m1, ch;
  logic [CCOUNT_W:0]             cpos_inc;
  logic signed [SAMPLE_BITS-1:0] mn_upd, mx_upd;
  logic [BW:0]                   acc_sum;
  logic [FRAME_W-1:0]            fpos_inc;

  assign full   = busy || bq_full;
  assign accept = push && !full;
  assign active = accept && setup_ok && (fpos_r < frame_count);

  // selected channel clamped to the last one present
  assign cc_m1 = channel_count - CCOUNT_W'(1);
  assign ch    = ({1'b0, channel_select} > cc_m1) ? cc_m1 : {1'b0, channel_select};
  assign hit   = (CCOUNT_W'(cpos_r) == ch);

  assign mn_upd = (hit && (sample < rmin_r)) ? sample : rmin_r;
  assign mx_upd = (hit && (sample > rmax_r)) ? sample : rmax_r;

  assign cpos_inc    = {1'b0, CCOUNT_W'(cpos_r)} + (CCOUNT_W+1)'(1);
  assign frame_done  = !(cpos_inc < {1'b0, channel_count});
  assign fpos_inc    = fpos_r + FRAME_W'(1);
  assign bucket_done = frame_done && (fpos_inc == end_r);
  assign acc_sum     = {1'b0, acc_r} + {1'b0, step_r};

  always_comb begin
    fpos_nxt   = fpos_r;
    cpos_nxt   = cpos_r;
    bnum_nxt   = bnum_r;
    end_nxt    = end_r;
    bstart_nxt = bstart_r;
    acc_nxt    = acc_r;
    rmin_nxt   = rmin_r;
    rmax_nxt   = rmax_r;
    priority if (restart) begin
      fpos_nxt   = '0;
      cpos_nxt   = '0;
      bnum_nxt   = '0;
      bstart_nxt = '0;
      rmin_nxt   = S_TOP;
      rmax_nxt   = S_BOT;
    end else if (init) begin
      // end of bucket 0 is F div B, the remainder seeds the accumulator
      end_nxt = step_q;
      acc_nxt = step_r;
    end else if (active) begin
      rmin_nxt = mn_upd;
      rmax_nxt = mx_upd;
      if (!frame_done) begin
        cpos_nxt = cpos_r + CPW'(1);
      end else begin
        cpos_nxt = '0;
        fpos_nxt = fpos_inc;
        if (bucket_done) begin
          bnum_nxt   = bnum_r + BW'(1);
          bstart_nxt = end_r;
          rmin_nxt   = S_TOP;
          rmax_nxt   = S_BOT;
          if (acc_sum >= {1'b0, bucket_total}) begin
            acc_nxt = BW'(acc_sum - {1'b0, bucket_total});
            end_nxt = end_r + step_q + FRAME_W'(1);
          end else begin
            acc_nxt = acc_sum[BW-1:0];
            end_nxt = end_r + step_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpos_r   <= '0;
      cpos_r   <= '0;
      bnum_r   <= '0;
      bstart_r <= '0;
      rmin_r   <= S_TOP;
      rmax_r   <= S_BOT;
    end else begin
      fpos_r   <= fpos_nxt;
      cpos_r   <= cpos_nxt;
      bnum_r   <= bnum_nxt;
      bstart_r <= bstart_nxt;
      rmin_r   <= rmin_nxt;
      rmax_r   <= rmax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    acc_r <= acc_nxt;
  end

  assign bq_push = active && bucket_done;
  assign bq_data = {bnum_r, bstart_r, mn_upd, mx_upd};

endmodule

### sv/mmep_back.sv
// ----------------------------------------------------------------------------
// mmep_back
// Pyramid builder: emits each closed bucket at level 0 and walks up the
// levels one per cycle while the result queue has room, pairing with the entry waiting at each level.
// ----------------------------------------------------------------------------
module mmep_back
  import mmep_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_LEVELS  = 8,
  parameter int BW          = 17,
  parameter int LV_W        = 4,
  parameter int BKT_W       = BW + FRAME_W + 2 * SAMPLE_BITS,
  parameter int RES_W       = LEVEL_W + INDEX_W + FRAME_W + 2 * SAMPLE_BITS + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [LV_W-1:0]  levels,
  input  logic             bq_empty,
  input  logic [BKT_W-1:0] bq_data,
  output logic             bq_pop,
  input  logic             rq_full,
  output logic             rq_push,
  output logic [RES_W-1:0] rq_data
);

  localparam int KW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  back_state_t                   state_r, state_nxt;
  logic [LV_W-1:0]               k_r, k_nxt;
  logic [BW-1:0]                 bnum_r, bnum_nxt;
  logic [FRAME_W-1:0]            start_r, start_nxt;
  logic signed [SAMPLE_BITS-1:0] mn_r, mn_nxt;
  logic signed [SAMPLE_BITS-1:0] mx_r, mx_nxt;

  logic                          pv_r   [MAX_LEVELS];
  logic signed [SAMPLE_BITS-1:0] pmin_r [MAX_LEVELS];
  logic signed [SAMPLE_BITS-1:0] pmax_r [MAX_LEVELS];
  logic [FRAME_W-1:0]            pst_r  [MAX_LEVELS];
  logic [BW-1:0]                 cnt_r  [MAX_LEVELS];

  logic                          emit, last, kn_in;
  logic [LV_W-1:0]               kn;
  logic [KW-1:0]                 ka, kna;
  logic [INDEX_W-1:0]            idx;
  logic                          park, join_up;

  assign kn    = k_r + LV_W'(1);
  assign ka    = k_r[KW-1:0];
  assign kna   = kn[KW-1:0];
  assign kn_in = (kn < levels);
  assign emit  = (state_r == BK_RUN) && !rq_full;
  // this entry ends the item unless the next level holds a partner
  assign last  = !kn_in || !pv_r[kna];
  assign idx   = (k_r == '0) ? INDEX_W'(bnum_r) : INDEX_W'(cnt_r[ka]);

  assign park    = emit && last && kn_in;
  assign join_up = emit && !last;

  assign bq_pop  = (state_r == BK_IDLE) && !bq_empty && !restart;
  assign rq_push = emit;
  assign rq_data = {LEVEL_W'(k_r), idx, start_r, mn_r, mx_r, last};

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    bnum_nxt  = bnum_r;
    start_nxt = start_r;
    mn_nxt    = mn_r;
    mx_nxt    = mx_r;
    unique case (state_r)
      BK_IDLE: begin
        if (bq_pop) begin
          {bnum_nxt, start_nxt, mn_nxt, mx_nxt} = bq_data;
          k_nxt     = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit) begin
          if (last) begin
            state_nxt = BK_IDLE;
          end else begin
            k_nxt     = kn;
            start_nxt = pst_r[kna];
            mn_nxt    = (pmin_r[kna] < mn_r) ? pmin_r[kna] : mn_r;
            mx_nxt    = (pmax_r[kna] > mx_r) ? pmax_r[kna] : mx_r;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (restart) begin
      state_nxt = BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pv_r[i]  <= 1'b0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (restart) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          pv_r[i]  <= 1'b0;
          cnt_r[i] <= '0;
        end
      end else begin
        if (emit && (k_r != '0)) begin
          cnt_r[ka] <= cnt_r[ka] + BW'(1);
        end
        if (park) begin
          pv_r[kna] <= 1'b1;
        end else if (join_up) begin
          pv_r[kna] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    bnum_r  <= bnum_nxt;
    start_r <= start_nxt;
    mn_r    <= mn_nxt;
    mx_r    <= mx_nxt;
    if (park) begin
      pmin_r[kna] <= mn_r;
      pmax_r[kna] <= mx_r;
      pst_r[kna]  <= start_r;
    end
  end

endmodule

### sv/min_max_envelope_pyramid.sv
// ----------------------------------------------------------------------------
// min_max_envelope_pyramid
// Min/max decimation envelope of one channel of an interleaved stream, with
// a halving pyramid of coarser levels built as base buckets close.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_sample                               push / full
//  result    out_level, out_entry_index,             empty / pop
//            out_start_frame, out_env_min,
//            out_env_max, out_last
//  config    cfg_index, cfg_data                     cfg_write_en, no wait
//
//  One sample is taken per cycle while the bucket queue has room and the divider is not busy.
//  The pyramid builder pops a closed bucket only when idle and gives 1 to
//  MAX_LEVELS results for it; the queue absorbs short bursts.
//  After each register write full stays high while the serial divider
//  works out frames per bucket.
//  Reset and register writes restart the stream at channel 0 of frame 0.
// ----------------------------------------------------------------------------
module min_max_envelope_pyramid
  import mmep_pkg::*;
#(
  parameter int MAX_POINTS   = 65536,
  parameter int MAX_LEVELS   = 8,
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output logic [LEVEL_W-1:0]            out_level,
  output logic [INDEX_W-1:0]            out_entry_index,
  output logic [FRAME_W-1:0]            out_start_frame,
  output logic signed [SAMPLE_BITS-1:0] out_env_min,
  output logic signed [SAMPLE_BITS-1:0] out_env_max,
  output logic                          out_last,
  input  logic                          cfg_write_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int BW    = $clog2(MAX_POINTS + 1);
  localparam int LV_W  = $clog2(MAX_LEVELS + 1);
  localparam int BKT_W = BW + FRAME_W + 2 * SAMPLE_BITS;
  localparam int RES_W = LEVEL_W + INDEX_W + FRAME_W + 2 * SAMPLE_BITS + 1;
  localparam int QDEPTH = 4;

  logic [FRAME_W-1:0]   frame_count_r;
  logic [CCOUNT_W-1:0]  channel_count_r;
  logic [CSEL_W-1:0]    channel_select_r;
  logic [TPOINTS_W-1:0] target_points_r;

  logic                 div_start_r;
  logic [FRAME_W-1:0]   b32_a, b32;
  logic [BW-1:0]        bucket_total;
  logic [LV_W-1:0]      levels_c, levels_r;
  logic                 setup_ok;
  logic [FRAME_W-1:0]   step_q;
  logic [BW-1:0]        step_r;
  logic                 div_busy, div_done, busy;

  logic                 bq_push, bq_full, bq_pop, bq_empty;
  logic [BKT_W-1:0]     bq_wdata, bq_rdata;
  logic                 rq_push, rq_full;
  logic [RES_W-1:0]     rq_wdata, rq_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r    <= '0;
      channel_count_r  <= CCOUNT_W'(1);
      channel_select_r <= '0;
      target_points_r  <= TPOINTS_W'(4096);
      div_start_r      <= 1'b0;
    end else begin
      div_start_r <= cfg_write_en;
      if (cfg_write_en) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_FRAME_COUNT:    frame_count_r    <= cfg_data;
          CFG_CHANNEL_COUNT:  channel_count_r  <= cfg_data[CCOUNT_W-1:0];
          CFG_CHANNEL_SELECT: channel_select_r <= cfg_data[CSEL_W-1:0];
          CFG_TARGET_POINTS:  target_points_r  <= cfg_data[TPOINTS_W-1:0];
        endcase
      end
    end
  end

  // bucket count and number of pyramid levels
  assign b32_a = (frame_count_r < FRAME_W'(target_points_r)) ?
                 frame_count_r : FRAME_W'(target_points_r);
  assign b32   = (b32_a < FRAME_W'(MAX_POINTS)) ? b32_a : FRAME_W'(MAX_POINTS);
  assign bucket_total = BW'(b32);

  always_comb begin
    levels_c = LV_W'(1);
    for (int j = 1; j < MAX_LEVELS; j++) begin
      if ((b32 >> (j - 1)) > FRAME_W'(LEVEL_LIMIT)) begin
        levels_c = LV_W'(j + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    levels_r <= levels_c;
  end

  assign setup_ok = (frame_count_r != '0) && (channel_count_r != '0) &&
                    (32'(channel_count_r) <= 32'(MAX_CHANNELS)) &&
                    (target_points_r != '0);

  mmep_div #(
    .BW (BW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (frame_count_r),
    .divisor   (bucket_total),
    .quotient  (step_q),
    .remainder (step_r),
    .busy      (div_busy),
    .done      (div_done)
  );

  assign busy = cfg_write_en || div_start_r || div_busy;

  mmep_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .BW           (BW),
    .BKT_W        (BKT_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (cfg_write_en),
    .init           (div_done),
    .busy           (busy),
    .setup_ok       (setup_ok),
    .frame_count    (frame_count_r),
    .channel_count  (channel_count_r),
    .channel_select (channel_select_r),
    .bucket_total   (bucket_total),
    .step_q         (step_q),
    .step_r         (step_r),
    .push           (push),
    .sample         (in_sample),
    .full           (full),
    .bq_push        (bq_push),
    .bq_data        (bq_wdata),
    .bq_full        (bq_full)
  );

  mmep_fifo #(
    .WIDTH (BKT_W),
    .DEPTH (QDEPTH)
  ) u_bucket_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_write_en),
    .wr_en   (bq_push),
    .wr_data (bq_wdata),
    .full    (bq_full),
    .rd_en   (bq_pop),
    .rd_data (bq_rdata),
    .empty   (bq_empty)
  );

  mmep_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_LEVELS  (MAX_LEVELS),
    .BW          (BW),
    .LV_W        (LV_W),
    .BKT_W       (BKT_W),
    .RES_W       (RES_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_write_en),
    .levels   (levels_r),
    .bq_empty (bq_empty),
    .bq_data  (bq_rdata),
    .bq_pop   (bq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_data  (rq_wdata)
  );

  mmep_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QDEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_write_en),
    .wr_en   (rq_push),
    .wr_data (rq_wdata),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (rq_rdata),
    .empty   (empty)
  );

  assign {out_level, out_entry_index, out_start_frame,
          out_env_min, out_env_max, out_last} = rq_rdata;

endmodule

### tb/tb_min_max_envelope_pyramid.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_max_envelope_pyramid
// Streams interleaved samples into the envelope pyramid and checks every
// entry, field by field, against an in-bench predictor of the base buckets
// and the halving levels. Covers register changes, invalid setups, point
// saturation, random idling on both sides and a long stall of the receiver.
// ----------------------------------------------------------------------------
module tb_min_max_envelope_pyramid;
  import mmep_pkg::*;

  localparam int SAMPLE_W      = 16;
  localparam int MAX_PTS       = 65536;
  localparam int MAX_LVLS      = 8;
  localparam int MAX_CHANS     = 8;
  localparam int SETTLE_CYCLES = 80;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int MAX_REPORTS   = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]          level;
    logic [INDEX_W-1:0]          index;
    logic [FRAME_W-1:0]          first;
    logic signed [SAMPLE_W-1:0]  lo;
    logic signed [SAMPLE_W-1:0]  hi;
    logic                        last;
  } env_entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  sample_t               in_sample;
  logic                  full;
  logic                  empty;
  logic                  pop;
  logic [LEVEL_W-1:0]    out_level;
  logic [INDEX_W-1:0]    out_entry_index;
  logic [FRAME_W-1:0]    out_start_frame;
  sample_t               out_env_min;
  sample_t               out_env_max;
  logic                  out_last;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register copies
  logic [FRAME_W-1:0]   reg_frames = '0;
  logic [CCOUNT_W-1:0]  reg_chans  = 4'd1;
  logic [CSEL_W-1:0]    reg_sel    = '0;
  logic [TPOINTS_W-1:0] reg_points = 17'd4096;

  // predictor state
  logic [FRAME_W-1:0] frame_pos;
  int unsigned        chan_pos;
  int unsigned        bucket_idx;
  logic [FRAME_W-1:0] bucket_end;
  logic [FRAME_W-1:0] bucket_first;
  sample_t            acc_min;
  sample_t            acc_max;
  sample_t            carry_min   [MAX_LVLS];
  sample_t            carry_max   [MAX_LVLS];
  logic [FRAME_W-1:0] carry_first [MAX_LVLS];
  bit                 carry_full  [MAX_LVLS];
  int unsigned        level_fill  [MAX_LVLS];

  env_entry_t  envelope_entries[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int          hold_left      = 0;
  int unsigned cycle_count;

  min_max_envelope_pyramid dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_sample       (in_sample),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .out_level       (out_level),
    .out_entry_index (out_entry_index),
    .out_start_frame (out_start_frame),
    .out_env_min     (out_env_min),
    .out_env_max     (out_env_max),
    .out_last        (out_last),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned bucket_total();
    longint unsigned n;
    n = reg_frames;
    if (reg_points < n) n = reg_points;
    if (MAX_PTS < n) n = MAX_PTS;
    return n;
  endfunction

  function automatic logic [FRAME_W-1:0] bucket_boundary(longint unsigned b,
                                                         longint unsigned nb);
    return FRAME_W'(((b + 1) * longint'(reg_frames)) / nb);
  endfunction

  function automatic int level_total(longint unsigned nb);
    int n;
    longint unsigned sz;
    n = 1;
    sz = nb;
    while (sz > LEVEL_LIMIT && n < MAX_LVLS) begin
      sz = sz / 2;
      n++;
    end
    return n;
  endfunction

  function automatic void restart_stream();
    frame_pos    = '0;
    chan_pos     = 0;
    bucket_idx   = 0;
    bucket_end   = '0;
    bucket_first = '0;
    acc_min      = {1'b0, {(SAMPLE_W-1){1'b1}}};
    acc_max      = {1'b1, {(SAMPLE_W-1){1'b0}}};
    for (int k = 0; k < MAX_LVLS; k++) begin
      carry_min[k]   = '0;
      carry_max[k]   = '0;
      carry_first[k] = '0;
      carry_full[k]  = 1'b0;
      level_fill[k]  = 0;
    end
  endfunction

  // folds one accepted sample into the running bucket and the levels above
  function automatic void track_sample(sample_t s);
    longint unsigned    nb;
    int unsigned        sel;
    int                 lvls;
    int                 k;
    sample_t            lo;
    sample_t            hi;
    logic [FRAME_W-1:0] first;
    env_entry_t         e;
    env_entry_t         batch[$];
    nb = bucket_total();
    if (reg_frames == 0 || reg_chans == 0 || reg_chans > MAX_CHANS || nb == 0) return;
    if (frame_pos >= reg_frames) return;
    if (bucket_idx == 0 && bucket_end == 0) bucket_end = bucket_boundary(0, nb);
    sel = reg_sel;
    if (sel > reg_chans - 1) sel = reg_chans - 1;
    if (chan_pos == sel) begin
      if (s < acc_min) acc_min = s;
      if (s > acc_max) acc_max = s;
    end
    if (chan_pos + 1 < reg_chans) begin
      chan_pos++;
      return;
    end
    chan_pos = 0;
    frame_pos++;
    if (frame_pos != bucket_end) return;

    lo = acc_min;
    hi = acc_max;
    first = bucket_first;
    e = '{level: '0, index: INDEX_W'(bucket_idx), first: first, lo: lo, hi: hi,
          last: 1'b0};
    batch = {batch, e};
    lvls = level_total(nb);
    for (k = 1; k < lvls; k++) begin
      if (!carry_full[k]) begin
        carry_full[k]  = 1'b1;
        carry_min[k]   = lo;
        carry_max[k]   = hi;
        carry_first[k] = first;
        break;
      end
      carry_full[k] = 1'b0;
      if (carry_min[k] < lo) lo = carry_min[k];
      if (carry_max[k] > hi) hi = carry_max[k];
      first = carry_first[k];
      e = '{level: LEVEL_W'(k), index: INDEX_W'(level_fill[k]), first: first,
            lo: lo, hi: hi, last: 1'b0};
      batch = {batch, e};
      level_fill[k]++;
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) envelope_entries = {envelope_entries, batch[i]};

    bucket_idx++;
    bucket_first = bucket_end;
    bucket_end   = bucket_boundary(bucket_idx, nb);
    acc_min      = {1'b0, {(SAMPLE_W-1){1'b1}}};
    acc_max      = {1'b1, {(SAMPLE_W-1){1'b0}}};
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_entry();
    env_entry_t e;
    if (envelope_entries.size() == 0) begin
      report_mismatch($sformatf("entry level %0d index %0d with none awaited",
                                out_level, out_entry_index));
      return;
    end
    e = envelope_entries.pop_front();
    if (out_level !== e.level)
      report_mismatch($sformatf("level %0d, want %0d", out_level, e.level));
    if (out_entry_index !== e.index)
      report_mismatch($sformatf("entry_index %0d, want %0d", out_entry_index, e.index));
    if (out_start_frame !== e.first)
      report_mismatch($sformatf("start_frame %0d, want %0d", out_start_frame, e.first));
    if (out_env_min !== e.lo)
      report_mismatch($sformatf("env_min %0d, want %0d", out_env_min, e.lo));
    if (out_env_max !== e.hi)
      report_mismatch($sformatf("env_max %0d, want %0d", out_env_max, e.hi));
    if (out_last !== e.last)
      report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
  endtask

  // result side: outputs are read at the edge, before the block updates them
  initial begin
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_entry();
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (full);
    track_sample(s);
  endtask

  // lets every awaited entry arrive, then gives the block time to go quiet
  task automatic wait_drained();
    push <= 1'b0;
    while (envelope_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [FRAME_W-1:0] frames,
                           input logic [CCOUNT_W-1:0] chans,
                           input logic [CSEL_W-1:0] sel,
                           input logic [TPOINTS_W-1:0] points);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_FRAME_COUNT;
    cfg_data     <= frames;
    @(posedge clk);
    cfg_index    <= CFG_CHANNEL_COUNT;
    cfg_data     <= CFG_DATA_W'(chans);
    @(posedge clk);
    cfg_index    <= CFG_CHANNEL_SELECT;
    cfg_data     <= CFG_DATA_W'(sel);
    @(posedge clk);
    cfg_index    <= CFG_TARGET_POINTS;
    cfg_data     <= CFG_DATA_W'(points);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    reg_frames = frames;
    reg_chans  = chans;
    reg_sel    = sel;
    reg_points = points;
    restart_stream();
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      default: return sample_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset leaves frame_count at zero, so nothing comes out
  task automatic test_reset_setup();
    send_sample(16'sd100);
    send_sample(-16'sd100);
  endtask

  task automatic test_sample_extremes();
    configure(32'd3, 4'd1, 3'd0, 17'd3);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    send_sample(16'sd0);
    send_sample(16'sd1);  // past the end of the clip
  endtask

  // channel_select above the channel count falls back to the last channel
  task automatic test_channel_clamp();
    configure(32'd2, 4'd2, 3'd7, 17'd1);
    send_sample(16'sd32767);
    send_sample(-16'sd5);
    send_sample(-16'sd32768);
    send_sample(16'sd100);
  endtask

  task automatic test_invalid_setups();
    configure(32'd4, 4'd0, 3'd0, 17'd4);
    repeat (2) send_sample(random_sample());
    configure(32'd4, 4'd15, 3'd0, 17'd4);
    repeat (2) send_sample(random_sample());
    configure(32'd4, 4'd1, 3'd0, 17'd0);
    repeat (2) send_sample(random_sample());
  endtask

  // bucket count capped at the maximum, giving the full set of levels
  task automatic test_point_saturation();
    configure(32'd70000, 4'd1, 3'd0, 17'h1FFFF);
    repeat (8) send_sample(random_sample());
  endtask

  // enough base buckets that the top level fires and one item gives every level
  task automatic test_full_pyramid();
    configure(32'd65536 + FRAME_W'($urandom_range(0, 4096)), 4'd1, CSEL_W'($urandom),
              17'h1FFFF);
    repeat (140) send_sample(random_sample());
  endtask

  task automatic test_backpressure();
    configure(32'd1024, 4'd1, 3'd0, 17'd1024);
    hold_left = 300;
    repeat (80) send_sample(random_sample());
    wait_drained();  // stream carries on from here
    repeat (20) send_sample(random_sample());
  endtask

  task automatic test_random_streams(input int unsigned budget);
    int unsigned          sent;
    int unsigned          count;
    logic [FRAME_W-1:0]   frames;
    logic [CCOUNT_W-1:0]  chans;
    logic [CSEL_W-1:0]    sel;
    logic [TPOINTS_W-1:0] points;
    sent = 0;
    while (sent < budget) begin
      chans  = CCOUNT_W'($urandom_range(1, MAX_CHANS));
      sel    = CSEL_W'($urandom);
      frames = FRAME_W'($urandom_range(1, 12));
      points = TPOINTS_W'($urandom_range(1, 16));
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       frames = '0;
            1:       chans  = '0;
            2:       chans  = CCOUNT_W'($urandom_range(MAX_CHANS + 1, 15));
            default: points = '0;
          endcase
          count = $urandom_range(2, 5);
        end
        1: begin
          chans  = CCOUNT_W'($urandom_range(1, 2));
          frames = FRAME_W'($urandom_range(513, 4000));
          points = TPOINTS_W'($urandom_range(513, 17'h1FFFF));
          count  = $urandom_range(30, 60);
        end
        2: begin
          // clip too long to finish a bucket
          frames = 32'hFFFF_FFFF - FRAME_W'($urandom_range(0, 3));
          count  = $urandom_range(2, 4);
        end
        default: count = frames * chans + $urandom_range(0, 4);
      endcase
      configure(frames, chans, sel, points);
      repeat (count) send_sample(random_sample());
      sent += count;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    in_sample    = '0;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_FRAME_COUNT;
    cfg_data     = '0;
    restart_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 66;
    test_reset_setup();
    test_sample_extremes();
    test_channel_clamp();
    test_invalid_setups();
    test_point_saturation();
    test_random_streams(30);
    test_full_pyramid();

    send_idle_pct = 66;
    recv_idle_pct = 22;
    test_random_streams(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(30);
    test_backpressure();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mmep_pkg.sv
sv/mmep_fifo.sv
sv/mmep_div.sv
sv/mmep_front.sv
sv/mmep_back.sv
sv/min_max_envelope_pyramid.sv
tb/tb_min_max_envelope_pyramid.sv
